// File: rtl/sacl_pkg.sv
// Shared types and constants for the set-associative cache tag block.
package sacl_pkg;

   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int OFFSET_W   = 4;
   localparam int SETIDX_W   = 3;
   // raw set index before folding onto the physical sets: up to 7 bits
   localparam int RAW_SET_W  = 7;
   localparam int SHIFT_W    = 5;
   localparam int OUT_WAY_W  = 2;
   localparam int COUNT_W    = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST    = 4'd4;
   localparam logic [SETIDX_W-1:0] SET_INDEX_BITS_RST = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS    = 1'b0,
      CSR_SET_INDEX_BITS = 1'b1
   } csr_idx_type;

endpackage

// File: rtl/sacl_if.sv
// Channel interfaces: lookup request, lookup response and register write.
interface sacl_req_if;
   logic                          valid;
   logic                          ready;
   logic [sacl_pkg::ADDR_W-1:0]   address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface sacl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [sacl_pkg::OUT_WAY_W-1:0] way;
   logic [sacl_pkg::COUNT_W-1:0]   hit_count;
   logic [sacl_pkg::COUNT_W-1:0]   access_count;

   modport source (output valid, output hit, output way, output hit_count,
                   output access_count, input ready);
   modport sink   (input valid, input hit, input way, input hit_count,
                   input access_count, output ready);
endinterface

interface sacl_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sacl_pkg::CSR_IDX_W-1:0]  index;
   logic [sacl_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sacl_lookup.sv
// Way compare, victim pick and true-LRU rank update for one set.
module sacl_lookup #(
   parameter int WAYS   = 4,
   parameter int RANK_W = 2,
   parameter int WAY_W  = 2
) (
   input  logic [WAYS-1:0]                     valid_bits,
   input  logic [WAYS-1:0][sacl_pkg::TAG_W-1:0] tags,
   input  logic [WAYS-1:0][RANK_W-1:0]         ranks_cur,
   input  logic [sacl_pkg::TAG_W-1:0]          tag,
   output logic                                hit,
   output logic [WAY_W-1:0]                    way,
   output logic [WAYS-1:0][RANK_W-1:0]         ranks_new
);

   logic              found;
   logic [RANK_W-1:0] used_rank;

   always_comb begin
      hit   = 1'b0;
      way   = '0;
      found = 1'b0;
      // highest-numbered matching way wins
      for (int w = 0; w < WAYS; w++) begin
         if (valid_bits[w] && (tags[w] == tag)) begin
            hit = 1'b1;
            way = WAY_W'(w);
         end
      end
      // miss: lowest-numbered way with the oldest rank
      if (!hit) begin
         for (int w = 0; w < WAYS; w++) begin
            if (!found && (ranks_cur[w] == '0)) begin
               way   = WAY_W'(w);
               found = 1'b1;
            end
         end
      end
      used_rank = ranks_cur[way];
      for (int w = 0; w < WAYS; w++) begin
         if (ranks_cur[w] > used_rank) begin
            ranks_new[w] = ranks_cur[w] - 1'b1;
         end else begin
            ranks_new[w] = ranks_cur[w];
         end
      end
      ranks_new[way] = RANK_W'(WAYS - 1);
   end

endmodule

// File: rtl/set_assoc_cache_lru_tags.sv
// Set-associative cache tag array with true-LRU replacement and hit/access counters.
// A request goes through the lookup stage and the response register. Throughput: one
// lookup per cycle unless the response stalls; the tag/rank row memory is read at the
// request edge and written when the lookup stage hands its result on, with same-set bypass.
// Reset (synchronous): valid bits, LRU validity, counters and pipeline valids clear at once;
// registers return to offset_bits 4, set_index_bits 4. No clearing pass is needed.
module set_assoc_cache_lru_tags #(
   parameter int WAYS = 4,
   parameter int SETS = 64
) (
   input logic        clock,
   input logic        reset,
   sacl_req_if.sink   req_if,
   sacl_rsp_if.source rsp_if,
   sacl_csr_if.sink   csr_if
);

   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W = WAY_W;
   localparam int RAW_DEPTH = 1 << sacl_pkg::RAW_SET_W;

   typedef struct packed {
      logic [WAYS-1:0][sacl_pkg::TAG_W-1:0] tags;
      logic [WAYS-1:0][RANK_W-1:0]          ranks;
   } row_type;

   // configuration
   logic [sacl_pkg::OFFSET_W-1:0] offset_bits_ff;
   logic [sacl_pkg::SETIDX_W-1:0] set_index_bits_ff;

   // address split
   logic [sacl_pkg::RAW_SET_W-1:0] raw_set;
   logic [sacl_pkg::RAW_SET_W-1:0] set_mask;
   logic [sacl_pkg::SHIFT_W-1:0]   tag_shift;
   logic [SET_W-1:0]               set_in;
   logic [sacl_pkg::TAG_W-1:0]     tag_in;
   logic [SET_W-1:0]               set_fold [RAW_DEPTH];

   // memory and valid bits
   row_type          row_mem [SETS];
   row_type          mem_rd_ff;
   logic [WAYS-1:0]  valid_ff [SETS];

   // lookup stage
   logic                       s1_valid_ff, s1_valid_in;
   logic [SET_W-1:0]           s1_set_ff;
   logic [sacl_pkg::TAG_W-1:0] s1_tag_ff;
   logic                       fwd_ff, fwd_in;
   row_type                    fwd_row_ff;
   row_type                    cur_row, new_row;
   logic [WAYS-1:0]            set_valid;
   logic [WAYS-1:0][RANK_W-1:0] reset_ranks, ranks_eff, ranks_upd;
   logic                       lk_hit;
   logic [WAY_W-1:0]           lk_way;
   logic                       s1_adv, req_fire;

   // counters and response register
   logic [sacl_pkg::COUNT_W-1:0]   hit_total_ff, hit_total_in;
   logic [sacl_pkg::COUNT_W-1:0]   access_total_ff, access_total_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff;
   logic [sacl_pkg::OUT_WAY_W-1:0] rsp_way_ff;
   logic [sacl_pkg::COUNT_W-1:0]   rsp_hit_count_ff, rsp_access_count_ff;

   // ---------------- configuration writes ----------------
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff    <= sacl_pkg::OFFSET_BITS_RST;
         set_index_bits_ff <= sacl_pkg::SET_INDEX_BITS_RST;
      end else if (csr_if.valid) begin
         case (sacl_pkg::csr_idx_type'(csr_if.index))
            sacl_pkg::CSR_OFFSET_BITS: begin
               offset_bits_ff <= csr_if.data[sacl_pkg::OFFSET_W-1:0];
            end
            sacl_pkg::CSR_SET_INDEX_BITS: begin
               set_index_bits_ff <= csr_if.data[sacl_pkg::SETIDX_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- address split ----------------
   // raw index folds onto the physical sets through a constant table
   for (genvar i = 0; i < RAW_DEPTH; i++) begin : g_fold
      assign set_fold[i] = SET_W'(i % SETS);
   end

   for (genvar w = 0; w < WAYS; w++) begin : g_rst_rank
      assign reset_ranks[w] = RANK_W'(w);
   end

   always_comb begin
      set_mask  = sacl_pkg::RAW_SET_W'((8'd1 << set_index_bits_ff) - 8'd1);
      raw_set   = sacl_pkg::RAW_SET_W'(req_if.address >> offset_bits_ff) & set_mask;
      tag_shift = sacl_pkg::SHIFT_W'(offset_bits_ff) + sacl_pkg::SHIFT_W'(set_index_bits_ff);
      tag_in    = req_if.address >> tag_shift;
      set_in    = set_fold[raw_set];
   end

   // ---------------- handshake ----------------
   assign s1_adv        = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || s1_adv;
   assign req_fire      = req_if.valid && req_if.ready;

   // previous lookup writes this set at the same edge the new one reads it
   assign fwd_in      = s1_adv && (s1_set_ff == set_in);
   assign s1_valid_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_set_ff  <= set_in;
         s1_tag_ff  <= tag_in;
         fwd_ff     <= fwd_in;
         fwd_row_ff <= new_row;
         mem_rd_ff  <= row_mem[set_in];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         row_mem[s1_set_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else if (s1_adv) begin
         valid_ff[s1_set_ff][lk_way] <= 1'b1;
      end
   end

   // ---------------- lookup stage ----------------
   always_comb begin
      cur_row   = fwd_ff ? fwd_row_ff : mem_rd_ff;
      set_valid = valid_ff[s1_set_ff];
      // a set never touched since reset holds the reset order
      ranks_eff = (|set_valid) ? cur_row.ranks : reset_ranks;
   end

   sacl_lookup #(
      .WAYS   (WAYS),
      .RANK_W (RANK_W),
      .WAY_W  (WAY_W)
   ) u_lookup (
      .valid_bits (set_valid),
      .tags       (cur_row.tags),
      .ranks_cur  (ranks_eff),
      .tag        (s1_tag_ff),
      .hit        (lk_hit),
      .way        (lk_way),
      .ranks_new  (ranks_upd)
   );

   always_comb begin
      new_row       = cur_row;
      new_row.ranks = ranks_upd;
      if (!lk_hit) begin
         new_row.tags[lk_way] = s1_tag_ff;
      end
      hit_total_in    = hit_total_ff + sacl_pkg::COUNT_W'(lk_hit);
      access_total_in = access_total_ff + 1'b1;
      rsp_valid_in    = s1_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   // ---------------- counters and response ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_total_ff    <= '0;
         access_total_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            hit_total_ff    <= hit_total_in;
            access_total_ff <= access_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_hit_ff          <= lk_hit;
         rsp_way_ff          <= sacl_pkg::OUT_WAY_W'(lk_way);
         rsp_hit_count_ff    <= hit_total_in;
         rsp_access_count_ff <= access_total_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.hit          = rsp_hit_ff;
   assign rsp_if.way          = rsp_way_ff;
   assign rsp_if.hit_count    = rsp_hit_count_ff;
   assign rsp_if.access_count = rsp_access_count_ff;

endmodule

// File: rtl/sacl_checker.sv
// Port-level checks for the cache tag block, bound to the top level.
module sacl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_hit,
   input logic [sacl_pkg::OUT_WAY_W-1:0] rsp_way,
   input logic [sacl_pkg::COUNT_W-1:0]   rsp_hit_count,
   input logic [sacl_pkg::COUNT_W-1:0]   rsp_access_count
);

   // no response survives a reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_way)
         && $stable(rsp_hit_count) && $stable(rsp_access_count))
      else $error("stalled response changed");

   // back-to-back responses: access count steps by one
   a_access_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) ##1 rsp_valid |->
         rsp_access_count == $past(rsp_access_count) + 1'b1)
      else $error("access count did not advance by one");

   // back-to-back responses: hit count steps only on a hit
   a_hit_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) ##1 rsp_valid |->
         rsp_hit_count == $past(rsp_hit_count) + sacl_pkg::COUNT_W'(rsp_hit))
      else $error("hit count inconsistent with hit flag");

endmodule

bind set_assoc_cache_lru_tags sacl_checker u_sacl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_hit          (rsp_if.hit),
   .rsp_way          (rsp_if.way),
   .rsp_hit_count    (rsp_if.hit_count),
   .rsp_access_count (rsp_if.access_count)
);
